[rtl/core/thv_pkg.sv]
// Shared types, constants and helper functions for the trade history VWAP block.
// Used by thv_mac, thv_div and trade_history_vwap; depends on nothing else.
package thv_pkg;

    // History storage
    localparam int HIST_DEPTH = 256;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);
    localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

    // Field widths
    localparam int PAIR_W   = 2;
    localparam int AMOUNT_W = 48;
    localparam int RATE_W   = 48;
    localparam int TIME_W   = 40;
    localparam int TRADES_W = 9;
    localparam int AGE_W    = 32;

    // Arithmetic widths: at most 511 terms of a 48 x 48 product, and of a 48-bit amount.
    localparam int PROD_W = RATE_W + AMOUNT_W;
    localparam int ACC_W  = PROD_W + TRADES_W;
    localparam int VSUM_W = AMOUNT_W + TRADES_W;
    localparam int QUOT_W = RATE_W;
    localparam int HALF_W = 24;

    // Stream widths
    localparam int S_TDATA_W = 176;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 64;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TRADES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TRADES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE       = 2'd2;
    localparam int CFG_DATA_W = 32;

    localparam logic [TRADES_W-1:0] WINDOW_RESET  = 9'd16;
    localparam logic [TRADES_W-1:0] MIN_RESET     = 9'd3;
    localparam logic [AGE_W-1:0]    MAX_AGE_RESET = 32'd86400;

    // Command codes
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Pair codes
    localparam logic [PAIR_W-1:0] PAIR_XMR     = 2'd0;
    localparam logic [PAIR_W-1:0] PAIR_ETH     = 2'd1;
    localparam logic [PAIR_W-1:0] PAIR_BCH     = 2'd2;
    localparam logic [PAIR_W-1:0] PAIR_UNKNOWN = 2'd3;

    // Seed rates in unsigned 32.16 fixed point
    localparam logic [RATE_W-1:0] SEED_XMR = 48'd34300 << 16;
    localparam logic [RATE_W-1:0] SEED_ETH = 48'd214000 << 16;
    localparam logic [RATE_W-1:0] SEED_BCH = 48'd46900 << 16;

    typedef struct packed {
        logic [PAIR_W-1:0]   pair;
        logic [AMOUNT_W-1:0] amount;
        logic [RATE_W-1:0]   rate;
        logic [TIME_W-1:0]   ts;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctl;

    function automatic logic [RATE_W-1:0] seed_rate(input logic [PAIR_W-1:0] pair);
        logic [RATE_W-1:0] rate;
        unique case (pair)
            PAIR_XMR: rate = SEED_XMR;
            PAIR_ETH: rate = SEED_ETH;
            PAIR_BCH: rate = SEED_BCH;
            default:  rate = '0;
        endcase
        return rate;
    endfunction

endpackage

[rtl/core/thv_mac.sv]
// Pipelined multiply-accumulate of rate times amount into a wide weighted sum.
// Depends on thv_pkg for widths and the control struct.
module thv_mac import thv_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_mac_ctl            i_ctl,
    input  logic [RATE_W-1:0]   i_rate,
    input  logic [AMOUNT_W-1:0] i_amount,
    output logic [ACC_W-1:0]    o_acc,
    output logic                o_busy
);

    logic                  r_v1;
    logic                  r_v2;
    logic [2*HALF_W-1:0]   r_p00;
    logic [2*HALF_W-1:0]   r_p01;
    logic [2*HALF_W-1:0]   r_p10;
    logic [2*HALF_W-1:0]   r_p11;
    logic [PROD_W-1:0]     r_prod;
    logic [ACC_W-1:0]      r_acc;
    logic [PROD_W-1:0]     w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
        end
    end

    // First stage: four 24 x 24 partial products.
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_p00 <= i_rate[HALF_W-1:0]        * i_amount[HALF_W-1:0];
            r_p01 <= i_rate[HALF_W-1:0]        * i_amount[2*HALF_W-1:HALF_W];
            r_p10 <= i_rate[2*HALF_W-1:HALF_W] * i_amount[HALF_W-1:0];
            r_p11 <= i_rate[2*HALF_W-1:HALF_W] * i_amount[2*HALF_W-1:HALF_W];
        end
    end

    assign w_prod = PROD_W'(r_p00)
                  + (PROD_W'(r_p01) << HALF_W)
                  + (PROD_W'(r_p10) << HALF_W)
                  + (PROD_W'(r_p11) << (2 * HALF_W));

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_v1 | r_v2;

endmodule

[rtl/core/thv_div.sv]
// Radix-2 restoring divider: weighted sum over amount sum, one quotient bit a cycle.
// Depends on thv_pkg for widths. The quotient is known to fit in QUOT_W bits.
module thv_div import thv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ACC_W-1:0]  i_num,
    input  logic [VSUM_W-1:0] i_den,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(QUOT_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [VSUM_W-1:0] r_rem;
    logic [VSUM_W-1:0] r_den;
    logic [QUOT_W-1:0] r_numlo;
    logic [QUOT_W-1:0] r_quot;
    logic [VSUM_W:0]   w_trial;
    logic              w_fits;

    assign w_trial = {r_rem, r_numlo[QUOT_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The upper part of the numerator is already below the divisor, so only
    // the low QUOT_W bits need a step each.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_num[ACC_W-1:QUOT_W];
            r_numlo <= i_num[QUOT_W-1:0];
            r_den   <= i_den;
            r_quot  <= '0;
        end else if (r_busy) begin
            r_rem   <= w_fits ? VSUM_W'(w_trial - {1'b0, r_den}) : w_trial[VSUM_W-1:0];
            r_numlo <= {r_numlo[QUOT_W-2:0], 1'b0};
            r_quot  <= {r_quot[QUOT_W-2:0], w_fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[rtl/core/trade_history_vwap.sv]
// Top level of the trade history VWAP block: history memory, walk control and result register.
// Depends on thv_pkg, thv_mac and thv_div.
//
// A record transaction stores one trade in a single-port history memory of HIST_DEPTH
// entries; the oldest trade is overwritten once the history is full.
// A query transaction walks the history from the newest trade, reading one entry a cycle
// from the memory port. From its acceptance until the next item can be accepted it passes
// through the walk, the multiply-accumulate drain and the hand-off to the output register.
// When an average is formed rather than the seed rate, the bit-serial divider runs
// between the drain and the hand-off. A result that still waits in the output register
// holds back the next hand-off. The block handles one item at a time; a finished result
// waits in the output register while the next item is accepted. The configuration port
// is always ready and should be written only while the block is idle.
module trade_history_vwap import thv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: trade_amount[47:0], trade_rate[95:48], trade_time[135:96], now_time[175:136]
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: cmd[0], pair[2:1]
    input  logic [S_TUSER_W-1:0]  i_s_axis_tuser,
    // Result stream.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: average_rate[47:0], trades_used[56:48], zero[63:57]
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    // tuser: used_seed[0]
    output logic                  o_m_axis_tuser,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]          r_state;
    logic [TRADES_W-1:0] r_window;
    logic [TRADES_W-1:0] r_min;
    logic [AGE_W-1:0]    r_max_age;
    logic [ADDR_W-1:0]   r_newest;
    logic [CNT_W-1:0]    r_stored;

    t_entry              r_mem [HIST_DEPTH];
    t_entry              r_rdata;
    logic                r_rd_valid;
    logic [ADDR_W-1:0]   r_rd_addr;
    logic [CNT_W-1:0]    r_seen;
    logic [TRADES_W-1:0] r_take;
    logic [VSUM_W-1:0]   r_vsum;
    logic [PAIR_W-1:0]   r_qpair;
    logic [TIME_W-1:0]   r_now;

    logic [RATE_W-1:0]   r_res_rate;
    logic                r_res_seed;
    logic                r_m_valid;
    logic [RATE_W-1:0]   r_m_rate;
    logic                r_m_seed;
    logic [TRADES_W-1:0] r_m_used;

    logic                w_s_acc;
    logic                w_cmd;
    logic [PAIR_W-1:0]   w_pair;
    t_entry              w_wentry;
    logic [ADDR_W-1:0]   w_wslot;
    logic                w_wr_en;
    logic                w_rd_en;
    logic [ADDR_W-1:0]   w_rd_next;
    logic                w_walk_end;
    logic [TIME_W-1:0]   w_age;
    logic                w_too_old;
    logic                w_take;
    logic                w_seed;
    logic                w_out_free;
    t_mac_ctl            w_mac_ctl;
    logic [ACC_W-1:0]    w_acc;
    logic                w_mac_busy;
    logic                w_div_start;
    logic                w_div_done;
    logic [QUOT_W-1:0]   w_quot;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cmd           = i_s_axis_tuser[0];
    assign w_pair          = i_s_axis_tuser[2:1];

    // Entry fields in order: pair, amount, rate, timestamp.
    assign w_wentry = {w_pair, i_s_axis_tdata[47:0], i_s_axis_tdata[95:48],
                       i_s_axis_tdata[135:96]};

    assign w_wslot = (r_stored == '0) ? '0
                   : (r_newest == ADDR_W'(HIST_DEPTH - 1)) ? '0 : r_newest + 1'b1;
    assign w_wr_en = w_s_acc && (w_cmd == CMD_RECORD);
    assign w_rd_en = (r_state == ST_WALK);
    assign w_rd_next = (r_rd_addr == '0) ? ADDR_W'(HIST_DEPTH - 1) : r_rd_addr - 1'b1;

    // History memory: one write port for records, one registered read for the walk.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wslot] <= w_wentry;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[r_rd_addr];
        end
    end

    // Entry evaluation on the registered read data.
    assign w_walk_end = (r_seen == r_stored) || (r_take >= r_window);
    assign w_age      = r_now - r_rdata.ts;
    assign w_too_old  = (r_max_age != '0) && (r_now > r_rdata.ts)
                     && (w_age > TIME_W'(r_max_age));
    assign w_take     = (r_state == ST_WALK) && r_rd_valid && !w_walk_end
                     && (r_rdata.pair == r_qpair) && !w_too_old;

    assign w_seed      = (r_take < r_min) || (r_vsum == '0);
    assign w_out_free  = !r_m_valid || i_m_axis_tready;
    assign w_div_start = (r_state == ST_DRAIN) && !w_mac_busy && !w_seed;

    assign w_mac_ctl.clear = w_s_acc && (w_cmd == CMD_QUERY);
    assign w_mac_ctl.valid = w_take;

    thv_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_rate   (r_rdata.rate),
        .i_amount (r_rdata.amount),
        .o_acc    (w_acc),
        .o_busy   (w_mac_busy)
    );

    thv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_acc),
        .i_den   (r_vsum),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= WINDOW_RESET;
            r_min     <= MIN_RESET;
            r_max_age <= MAX_AGE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WINDOW_TRADES: r_window  <= i_cfg_data[TRADES_W-1:0];
                CFG_MIN_TRADES:    r_min     <= i_cfg_data[TRADES_W-1:0];
                CFG_MAX_AGE:       r_max_age <= i_cfg_data[AGE_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_newest   <= '0;
            r_stored   <= '0;
            r_rd_valid <= 1'b0;
            r_seen     <= '0;
            r_take     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_s_acc) begin
                        if (w_cmd == CMD_RECORD) begin
                            r_newest <= w_wslot;
                            if (r_stored != CNT_W'(HIST_DEPTH)) begin
                                r_stored <= r_stored + 1'b1;
                            end
                        end else begin
                            r_seen     <= '0;
                            r_take     <= '0;
                            r_rd_valid <= 1'b0;
                            r_state    <= ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    r_rd_valid <= !(r_rd_valid && w_walk_end);
                    if (r_rd_valid) begin
                        if (w_walk_end) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_seen <= r_seen + 1'b1;
                            if (w_take) begin
                                r_take <= r_take + 1'b1;
                            end
                        end
                    end
                end
                ST_DRAIN: begin
                    if (!w_mac_busy) begin
                        r_state <= w_seed ? ST_OUT : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // A new result is loaded when the old one is gone or being taken in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (r_m_valid && i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // Walk payload: read address, query fields and the amount sum.
    always_ff @(posedge i_clk) begin
        if (w_s_acc && (w_cmd == CMD_QUERY)) begin
            r_rd_addr <= r_newest;
            r_qpair   <= w_pair;
            r_now     <= i_s_axis_tdata[175:136];
            r_vsum    <= '0;
        end else begin
            if (w_rd_en) begin
                r_rd_addr <= w_rd_next;
            end
            if (w_take) begin
                r_vsum <= r_vsum + VSUM_W'(r_rdata.amount);
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DRAIN) && !w_mac_busy && w_seed) begin
            r_res_rate <= seed_rate(r_qpair);
            r_res_seed <= 1'b1;
        end else if ((r_state == ST_DIV) && w_div_done) begin
            r_res_rate <= w_quot;
            r_res_seed <= 1'b0;
        end
        if ((r_state == ST_OUT) && w_out_free) begin
            r_m_rate <= r_res_rate;
            r_m_seed <= r_res_seed;
            r_m_used <= r_take;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W - RATE_W - TRADES_W){1'b0}}, r_m_used, r_m_rate};
    assign o_m_axis_tuser  = r_m_seed;

`ifndef ASSERT_OFF
    a_stored_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= CNT_W'(HIST_DEPTH))
        else $error("history count exceeds the depth");

    a_take_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W'(r_take) <= r_seen) && (r_seen <= r_stored))
        else $error("walk counters out of order");

    a_record_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && (w_cmd == CMD_RECORD)) |=>
            (r_stored == $past(r_stored) + 1'b1) || (r_stored == CNT_W'(HIST_DEPTH)))
        else $error("record transaction did not update the history count");

    a_query_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && (w_cmd == CMD_QUERY)) |=> (r_state == ST_WALK))
        else $error("query transaction did not start a walk");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");
`endif

endmodule
